// ----- rtl/core/srtf_pkg.sv -----
// Shared types and constants of the shortest-remaining-time-first tick scheduler.
// Used by the divider and the top level; no dependencies of its own.
package srtf_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_BITS  = $clog2(MAX_JOBS);
    localparam int CNT_BITS  = $clog2(MAX_JOBS + 1);
    localparam int TURN_BITS = TIME_BITS + 1;
    localparam int PEN_BITS  = TURN_BITS + 8;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_FULL   = 2'd1,
        ST_RAN    = 2'd2,
        ST_IDLE   = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DIV,
        S_DONE
    } state_t;

    // One job table entry as it lies in the RAM.
    typedef struct packed {
        logic [TIME_BITS-1:0] first_run;
        logic [TIME_BITS-1:0] left;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] arrival;
    } entry_t;

    typedef struct packed {
        status_t               status;
        logic [3:0]            job_index;
        logic [TIME_BITS-1:0]  tick_time;
        logic [TIME_BITS-1:0]  remaining;
        logic                  finished;
        logic [TIME_BITS-1:0]  wait_time;
        logic [TURN_BITS-1:0]  turnaround;
        logic [PEN_BITS-1:0]   penalty;
    } result_t;

endpackage

// ----- rtl/core/srtf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/srtf_div.sv -----
// Restoring divider for the penalty ratio, one quotient bit per cycle.
// Depends on srtf_pkg for the operand widths.
module srtf_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [srtf_pkg::PEN_BITS-1:0]  dividend,
    input  logic [srtf_pkg::TIME_BITS-1:0] divisor,
    output logic                           done,
    output logic [srtf_pkg::PEN_BITS-1:0]  quotient
);

    localparam int STEP_BITS = $clog2(srtf_pkg::PEN_BITS);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [STEP_BITS-1:0]           step_reg, step_next;
    logic [srtf_pkg::PEN_BITS-1:0]  quo_reg, quo_next;
    logic [srtf_pkg::TIME_BITS-1:0] rem_reg, rem_next;
    logic [srtf_pkg::TIME_BITS-1:0] dvs_reg, dvs_next;
    logic [srtf_pkg::TIME_BITS:0]   trial;
    logic                           fits;

    // The quotient register shifts dividend bits out at the top and
    // quotient bits in at the bottom.
    assign trial = {rem_reg, quo_reg[srtf_pkg::PEN_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[srtf_pkg::PEN_BITS-2:0], fits};
            rem_next  = fits ? srtf_pkg::TIME_BITS'(trial - {1'b0, dvs_reg})
                             : srtf_pkg::TIME_BITS'(trial);
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_BITS'(srtf_pkg::PEN_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/srtf_tick_scheduler_unit.sv -----
// Shortest-remaining-time-first tick scheduler: sequencer, job table RAM and divider.
// Depends on srtf_pkg, srtf_ram and srtf_div.
//
// Usage: each input item on the s_ channel is either a load (s_tuser = 0), which
// appends a job (arrival, burst) to a 16-entry table, or a tick (s_tuser = 1),
// which runs the eligible job with the least remaining time for one time unit.
// Every item yields exactly one result item on the m_ channel; m_tuser carries
// the status code and m_tdata the job figures.
// Sequence: a load goes through S_DONE to the output register. A tick scans
// the table of loaded jobs with one RAM read per cycle, writes the chosen entry
// back in S_WRITE, and waits in S_DIV for the penalty quotient (25 quotient bits)
// of the bit-serial divider and its done flag, then hands the result over from
// S_DONE. An idle tick or a zero wait skips the divider.
// One item is worked on at a time; s_tready is high only while the sequencer
// is idle, so no new item is accepted before the last one is through.
// A finished result sits in the output register; the next item is accepted
// while it waits. If m_tready stays low, the following result is held in the
// sequencer and no further item is accepted until the output register frees.
// Reset empties the table, clears the started flags and sets time to zero.
module srtf_tick_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // arrival[15:0], burst[31:16]
    input  logic        s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // job_index[3:0], tick_time[19:4], remaining[35:20],
                                   // finished[36], wait_time[52:37], turnaround[69:53],
                                   // penalty[94:70], zero pad[95]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int TB = srtf_pkg::TIME_BITS;
    localparam int IB = srtf_pkg::IDX_BITS;
    localparam int CB = srtf_pkg::CNT_BITS;

    srtf_pkg::state_t  state_reg, state_next;
    logic [CB-1:0]     addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic [IB-1:0]     pidx_reg, pidx_next;
    logic              found_reg, found_next;
    logic [IB-1:0]     bidx_reg, bidx_next;
    srtf_pkg::entry_t  best_reg, best_next;
    logic [CB-1:0]     count_reg, count_next;
    logic [TB-1:0]     now_reg, now_next;
    logic [srtf_pkg::MAX_JOBS-1:0] started_reg, started_next;
    srtf_pkg::result_t res_reg, res_next;
    srtf_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              ram_we, ram_re;
    logic [IB-1:0]     ram_waddr, ram_raddr;
    srtf_pkg::entry_t  ram_wdata, ram_rdata;

    logic                          div_start, div_done;
    logic [srtf_pkg::PEN_BITS-1:0] div_quo;

    logic              in_accept, scan_end, out_free, eligible;
    logic [TB-1:0]     in_arrival, in_burst;
    logic [TB-1:0]     first_run, wait_val;
    logic [srtf_pkg::TURN_BITS-1:0] turn_val;
    srtf_pkg::entry_t  upd;

    srtf_ram #(
        .WIDTH ($bits(srtf_pkg::entry_t)),
        .DEPTH (srtf_pkg::MAX_JOBS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srtf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({turn_val, 8'd0}),
        .divisor  (wait_val),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_accept  = s_tvalid && s_tready;
    assign in_arrival = s_tdata[TB-1:0];
    assign in_burst   = s_tdata[2*TB-1:TB];
    assign scan_end   = (addr_reg == count_reg) && !pend_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign eligible   = (ram_rdata.arrival <= now_reg) && (ram_rdata.left != '0);

    // The tick time was captured at the end of the scan; a first run uses it.
    assign first_run = started_reg[bidx_reg] ? best_reg.first_run : res_reg.tick_time;
    assign wait_val  = first_run - best_reg.arrival;
    assign turn_val  = {1'b0, wait_val} + {1'b0, best_reg.burst};

    always_comb
    begin
        upd           = best_reg;
        upd.left      = best_reg.left - 1'b1;
        upd.first_run = first_run;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtf_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_tuser == srtf_pkg::FUNC_LOAD) ? srtf_pkg::S_DONE
                                                                  : srtf_pkg::S_SCAN;
                end
            end
            srtf_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = found_reg ? srtf_pkg::S_WRITE : srtf_pkg::S_DONE;
                end
            end
            srtf_pkg::S_WRITE:
            begin
                state_next = (wait_val != '0) ? srtf_pkg::S_DIV : srtf_pkg::S_DONE;
            end
            srtf_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = srtf_pkg::S_DONE;
                end
            end
            srtf_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = srtf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srtf_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        bidx_next      = bidx_reg;
        best_next      = best_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        started_next   = started_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_waddr      = bidx_reg;
        ram_wdata      = upd;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg[IB-1:0];
        div_start      = 1'b0;
        s_tready       = (state_reg == srtf_pkg::S_IDLE);

        unique case (state_reg)
            srtf_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    res_next = '0;
                    if (s_tuser == srtf_pkg::FUNC_LOAD)
                    begin
                        if (count_reg == CB'(srtf_pkg::MAX_JOBS))
                        begin
                            res_next.status = srtf_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = count_reg[IB-1:0];
                            ram_wdata.arrival   = in_arrival;
                            ram_wdata.burst     = in_burst;
                            ram_wdata.left      = in_burst;
                            ram_wdata.first_run = '0;
                            started_next[count_reg[IB-1:0]] = 1'b0;
                            count_next          = count_reg + 1'b1;
                            res_next.status     = srtf_pkg::ST_LOADED;
                            res_next.job_index  = 4'(count_reg);
                        end
                    end
                    else
                    begin
                        addr_next  = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                    end
                end
            end
            srtf_pkg::S_SCAN:
            begin
                // One read issued per cycle; its data is judged the cycle after.
                pend_next = 1'b0;
                if (addr_reg != count_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = addr_reg[IB-1:0];
                    addr_next = addr_reg + 1'b1;
                end
                if (pend_reg && eligible && (!found_reg || ram_rdata.left < best_reg.left))
                begin
                    found_next = 1'b1;
                    bidx_next  = pidx_reg;
                    best_next  = ram_rdata;
                end
                if (scan_end)
                begin
                    res_next.tick_time = now_reg;
                    res_next.status    = srtf_pkg::ST_IDLE;
                    if (now_reg != srtf_pkg::TIME_MAX)
                    begin
                        now_next = now_reg + 1'b1;
                    end
                end
            end
            srtf_pkg::S_WRITE:
            begin
                ram_we                 = 1'b1;
                started_next[bidx_reg] = 1'b1;
                res_next.status        = srtf_pkg::ST_RAN;
                res_next.job_index     = 4'(bidx_reg);
                res_next.remaining     = upd.left;
                res_next.finished      = (upd.left == '0);
                res_next.wait_time     = wait_val;
                res_next.turnaround    = turn_val;
                res_next.penalty       = '0;
                div_start              = (wait_val != '0);
            end
            srtf_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    res_next.penalty = div_quo;
                end
            end
            srtf_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtf_pkg::S_IDLE;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            now_reg       <= '0;
            started_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        bidx_reg <= bidx_next;
        best_reg <= best_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.penalty, out_reg.turnaround, out_reg.wait_time,
                       out_reg.finished, out_reg.remaining, out_reg.tick_time,
                       out_reg.job_index};

endmodule
